// File: sv/hcrp_pkg.sv
// ============================================================================
// hcrp_pkg: shared constants and helpers for the HTTP chunked response parser
// Character codes, value-matcher state codes and byte-class functions.
// ============================================================================
package hcrp_pkg;

  // Default width of length, chunk-size and body counters
  localparam int LENGTH_BITS_DEF = 32;

  // Item command codes
  localparam logic [1:0] CMD_DATA   = 2'd0;
  localparam logic [1:0] CMD_RXFAIL = 2'd1;

  // Outcome codes
  localparam logic [1:0] OUT_OK     = 2'd0;
  localparam logic [1:0] OUT_RXFAIL = 2'd1;
  localparam logic [1:0] OUT_CLOSED = 2'd2;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;

  // Header name lengths
  localparam logic [4:0] CL_LEN  = 5'd14;
  localparam logic [4:0] TE_LEN  = 5'd17;
  localparam logic [4:0] POS_MAX = 5'd31;

  // Header name candidate sets
  localparam logic [1:0] CAND_NONE = 2'd0;
  localparam logic [1:0] CAND_CL   = 2'd1;
  localparam logic [1:0] CAND_TE   = 2'd2;
  localparam logic [1:0] CAND_BOTH = 2'd3;

  // Status token matcher
  localparam logic [3:0] SV_START  = 4'd0;
  localparam logic [3:0] SV_PLUS   = 4'd1;
  localparam logic [3:0] SV_DIGITS = 4'd2;
  localparam logic [3:0] SV_END    = 4'd3;
  localparam logic [3:0] SV_BAD    = 4'd4;

  // Content-Length matcher
  localparam logic [3:0] LV_START  = 4'd0;
  localparam logic [3:0] LV_PLUS   = 4'd1;
  localparam logic [3:0] LV_MINUS  = 4'd2;
  localparam logic [3:0] LV_DIGITS = 4'd3;
  localparam logic [3:0] LV_NEGDIG = 4'd4;
  localparam logic [3:0] LV_END    = 4'd5;
  localparam logic [3:0] LV_NEGEND = 4'd6;
  localparam logic [3:0] LV_BAD    = 4'd7;

  // Transfer-Encoding matcher: progress codes 1..6 walk "chunked"
  localparam logic [3:0] EV_START   = 4'd0;
  localparam logic [3:0] EV_FIRST   = 4'd1;
  localparam logic [3:0] EV_LAST    = 4'd6;
  localparam logic [3:0] EV_MATCHED = 4'd7;
  localparam logic [3:0] EV_BAD     = 4'd15;

  // Chunk-size parser
  localparam logic [1:0] HX_START  = 2'd0;
  localparam logic [1:0] HX_ZERO   = 2'd1;
  localparam logic [1:0] HX_DIGITS = 2'd2;
  localparam logic [1:0] HX_STOP   = 2'd3;

  localparam logic [9:0]  STATUS_MAX = 10'd999;
  localparam logic [1:0]  TRAIL_SKIP = 2'd2;
  localparam logic [1:0]  TOK_MAX    = 2'd3;
  localparam logic [1:0]  TOK_CODE   = 2'd2;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_dec(c)) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // "Content-Length"
  function automatic logic [7:0] cl_char(input logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd0:  r = 8'h43;
      5'd1:  r = 8'h6F;
      5'd2:  r = 8'h6E;
      5'd3:  r = 8'h74;
      5'd4:  r = 8'h65;
      5'd5:  r = 8'h6E;
      5'd6:  r = 8'h74;
      5'd7:  r = 8'h2D;
      5'd8:  r = 8'h4C;
      5'd9:  r = 8'h65;
      5'd10: r = 8'h6E;
      5'd11: r = 8'h67;
      5'd12: r = 8'h74;
      5'd13: r = 8'h68;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "Transfer-Encoding"
  function automatic logic [7:0] te_char(input logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd0:  r = 8'h54;
      5'd1:  r = 8'h72;
      5'd2:  r = 8'h61;
      5'd3:  r = 8'h6E;
      5'd4:  r = 8'h73;
      5'd5:  r = 8'h66;
      5'd6:  r = 8'h65;
      5'd7:  r = 8'h72;
      5'd8:  r = 8'h2D;
      5'd9:  r = 8'h45;
      5'd10: r = 8'h6E;
      5'd11: r = 8'h63;
      5'd12: r = 8'h6F;
      5'd13: r = 8'h64;
      5'd14: r = 8'h69;
      5'd15: r = 8'h6E;
      5'd16: r = 8'h67;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "chunked", positions 1..6 (first char checked separately)
  function automatic logic [7:0] ck_char(input logic [3:0] s);
    logic [7:0] r;
    case (s)
      4'd1: r = 8'h68;
      4'd2: r = 8'h75;
      4'd3: r = 8'h6E;
      4'd4: r = 8'h6B;
      4'd5: r = 8'h65;
      4'd6: r = 8'h64;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: sv/http_chunked_response_parser_core.sv
// ============================================================================
// http_chunked_response_parser_core
// Byte-wide HTTP/1.1 response parser: status code, Content-Length,
// Transfer-Encoding: chunked, and body byte extraction.
// ============================================================================
// One received byte enters per cycle: the byte is captured in an input
// register, the status/header matchers, decimal and hex accumulators
// and body counters update in a single pass, and any result
// lands in an output register. Sustained rate is one request per clock while
// out_tready stays high; a held result stalls the input only when the input
// register is also full. Each result carries the committed status code, a
// body byte when body_valid is set, and tlast on the final result of a
// response. After reset the parser behaves as if a new response had begun
// with headers still to be read. Once a response has finished, requests
// without new_response are consumed and produce no result.
module http_chunked_response_parser_core
  import hcrp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [3:0]  in_tuser,   // [1:0] command, [2] new_response, [3] headers_already_done
  input  logic        in_tlast,   // segment_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] body_byte, [17:8] status_code, [23:18] zero
  output logic [2:0]  out_tuser,  // [0] body_valid, [2:1] outcome
  output logic        out_tlast   // response_done
);

  typedef enum logic [2:0] {
    PH_STATUS, PH_HNAME, PH_HVALUE, PH_BODY, PH_CSIZE, PH_CDATA, PH_CTRAIL, PH_DONE
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  // input register
  logic             in_v_r;
  logic [1:0]       cmd_r;
  logic [7:0]       byte_r;
  logic             seg_r, newr_r, hdr_r;

  // output register
  logic             out_v_r;
  logic             o_bvalid_r, o_done_r;
  logic [7:0]       o_byte_r;
  logic [1:0]       o_outcome_r;
  logic [9:0]       o_status_r;

  // parser state
  phase_t                 phase_r, phase_nxt;
  logic                   cr_r, cr_nxt;
  logic [1:0]             tok_r, tok_nxt;
  logic [9:0]             stat_val_r, stat_val_nxt;
  logic [9:0]             stat_acc_r, stat_acc_nxt;
  logic                   in_token_r, in_token_nxt;
  logic [4:0]             pos_r, pos_nxt;
  logic [1:0]             cand_r, cand_nxt;
  logic [3:0]             vms_r, vms_nxt;
  logic [LENGTH_BITS-1:0] num_r, num_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   len_known_r, len_known_nxt;
  logic                   chunked_r, chunked_nxt;
  logic [LENGTH_BITS-1:0] chunk_rem_r, chunk_rem_nxt;
  logic [1:0]             hex_st_r, hex_st_nxt;
  logic                   hex_seen_r, hex_seen_nxt;
  logic [1:0]             trail_r, trail_nxt;
  logic [LENGTH_BITS-1:0] body_cnt_r, body_cnt_nxt;
  logic                   fin_r, fin_nxt;
  logic                   line_st_r, line_st_nxt;

  // step results
  logic       res_valid, r_bvalid;
  logic [7:0] r_byte;
  logic [1:0] r_outcome;
  logic       advance;

  // byte classification and accumulator pushes
  logic                   b_dec, b_ws;
  logic [4:0]             b_hex;
  logic [3:0]             b_digit;
  logic [13:0]            stat_wide;
  logic [9:0]             stat_push;
  logic [LENGTH_BITS+3:0] dec_wide;
  logic [LENGTH_BITS-1:0] dec_push, hex_push;

  assign b_dec   = is_dec(byte_r);
  assign b_ws    = is_ws(byte_r);
  assign b_hex   = hex_val(byte_r);
  assign b_digit = byte_r[3:0];

  // status accumulator: acc*10 + d, saturating at 999
  assign stat_wide = ({4'd0, stat_acc_r} << 3) + ({4'd0, stat_acc_r} << 1) + {10'd0, b_digit};
  assign stat_push = (stat_wide > {4'd0, STATUS_MAX}) ? STATUS_MAX : stat_wide[9:0];

  // decimal length push, saturating
  assign dec_wide = ({4'd0, num_r} << 3) + ({4'd0, num_r} << 1)
                  + {{LENGTH_BITS{1'b0}}, b_digit};
  assign dec_push = (dec_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MASK
                                                                  : dec_wide[LENGTH_BITS-1:0];

  // hex chunk-size push, saturating
  assign hex_push = (num_r[LENGTH_BITS-1:LENGTH_BITS-4] != 4'd0) ? LEN_MASK
                                                                 : {num_r[LENGTH_BITS-5:0], b_hex[3:0]};

  // handshake
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  // one parsing step
  always_comb begin
    phase_nxt     = phase_r;
    cr_nxt        = cr_r;
    tok_nxt       = tok_r;
    stat_val_nxt  = stat_val_r;
    stat_acc_nxt  = stat_acc_r;
    in_token_nxt  = in_token_r;
    pos_nxt       = pos_r;
    cand_nxt      = cand_r;
    vms_nxt       = vms_r;
    num_nxt       = num_r;
    len_nxt       = len_r;
    len_known_nxt = len_known_r;
    chunked_nxt   = chunked_r;
    chunk_rem_nxt = chunk_rem_r;
    hex_st_nxt    = hex_st_r;
    hex_seen_nxt  = hex_seen_r;
    trail_nxt     = trail_r;
    body_cnt_nxt  = body_cnt_r;
    fin_nxt       = fin_r;
    line_st_nxt   = line_st_r;
    r_bvalid      = 1'b0;
    r_byte        = 8'd0;
    r_outcome     = OUT_OK;
    res_valid     = 1'b0;

    // new response clears per-response state
    if (newr_r) begin
      phase_nxt     = hdr_r ? PH_BODY : PH_STATUS;
      cr_nxt        = 1'b0;
      tok_nxt       = 2'd0;
      stat_val_nxt  = 10'd0;
      stat_acc_nxt  = 10'd0;
      in_token_nxt  = 1'b0;
      len_nxt       = LEN_ZERO;
      len_known_nxt = 1'b0;
      chunked_nxt   = 1'b0;
      chunk_rem_nxt = LEN_ZERO;
      trail_nxt     = 2'd0;
      body_cnt_nxt  = LEN_ZERO;
      fin_nxt       = 1'b0;
      hex_st_nxt    = HX_START;
      hex_seen_nxt  = 1'b0;
      num_nxt       = LEN_ZERO;
      line_st_nxt   = 1'b0;
      pos_nxt       = 5'd0;
      cand_nxt      = CAND_BOTH;
      vms_nxt       = 4'd0;
    end

    if (!fin_nxt) begin
      if (cmd_r != CMD_DATA) begin
        fin_nxt   = 1'b1;
        phase_nxt = PH_DONE;
        r_outcome = (cmd_r == CMD_RXFAIL) ? OUT_RXFAIL : OUT_CLOSED;
      end else begin
        unique case (phase_nxt)
          PH_STATUS, PH_HNAME, PH_HVALUE, PH_CSIZE: begin
            if (cr_nxt && byte_r == CH_LF) begin
              // line end on CR LF
              cr_nxt = 1'b0;
              unique case (phase_nxt)
                PH_STATUS, PH_HNAME: begin
                  if (!line_st_nxt) begin
                    if (chunked_nxt) begin
                      phase_nxt    = PH_CSIZE;
                      hex_st_nxt   = HX_START;
                      hex_seen_nxt = 1'b0;
                    end else begin
                      phase_nxt = PH_BODY;
                    end
                  end else if (phase_nxt == PH_STATUS) begin
                    stat_val_nxt = (vms_nxt == SV_DIGITS || vms_nxt == SV_END) ?
                                   stat_acc_nxt : 10'd0;
                    phase_nxt    = PH_HNAME;
                  end
                  line_st_nxt = 1'b0;
                  pos_nxt     = 5'd0;
                  cand_nxt    = CAND_BOTH;
                  vms_nxt     = 4'd0;
                  num_nxt     = LEN_ZERO;
                end
                PH_HVALUE: begin
                  if (cand_nxt == CAND_CL) begin
                    if (vms_nxt == LV_DIGITS || vms_nxt == LV_END) begin
                      len_nxt       = num_nxt;
                      len_known_nxt = 1'b1;
                    end else if (vms_nxt == LV_NEGDIG || vms_nxt == LV_NEGEND) begin
                      len_known_nxt = 1'b0;
                    end
                  end else if (cand_nxt == CAND_TE && vms_nxt == EV_MATCHED) begin
                    chunked_nxt = 1'b1;
                  end
                  phase_nxt   = PH_HNAME;
                  line_st_nxt = 1'b0;
                  pos_nxt     = 5'd0;
                  cand_nxt    = CAND_BOTH;
                  vms_nxt     = 4'd0;
                  num_nxt     = LEN_ZERO;
                end
                default: begin
                  // chunk-size line
                  if (hex_seen_nxt) begin
                    if (num_nxt == LEN_ZERO) begin
                      fin_nxt   = 1'b1;
                      phase_nxt = PH_DONE;
                    end else begin
                      chunk_rem_nxt = num_nxt;
                      phase_nxt     = PH_CDATA;
                    end
                  end
                  hex_st_nxt   = HX_START;
                  hex_seen_nxt = 1'b0;
                  num_nxt      = LEN_ZERO;
                end
              endcase
            end else begin
              // a held CR not followed by LF is an ordinary character
              if (cr_nxt) begin
                cr_nxt = 1'b0;
                unique case (phase_nxt)
                  PH_STATUS: begin
                    line_st_nxt = 1'b1;
                    if (!in_token_nxt) begin
                      in_token_nxt = 1'b1;
                      if (tok_nxt < TOK_MAX) tok_nxt = tok_nxt + 2'd1;
                    end
                    if (tok_nxt == TOK_CODE) begin
                      if (vms_nxt == SV_PLUS) vms_nxt = SV_BAD;
                      else if (vms_nxt == SV_DIGITS) vms_nxt = SV_END;
                    end
                  end
                  PH_HNAME: begin
                    line_st_nxt = 1'b1;
                    cand_nxt    = CAND_NONE;
                    if (pos_nxt < POS_MAX) pos_nxt = pos_nxt + 5'd1;
                  end
                  PH_HVALUE: begin
                    if (cand_nxt == CAND_CL) begin
                      if (vms_nxt == LV_PLUS || vms_nxt == LV_MINUS) vms_nxt = LV_BAD;
                      else if (vms_nxt == LV_DIGITS) vms_nxt = LV_END;
                      else if (vms_nxt == LV_NEGDIG) vms_nxt = LV_NEGEND;
                    end else if (cand_nxt == CAND_TE) begin
                      if (vms_nxt >= EV_FIRST && vms_nxt <= EV_LAST) vms_nxt = EV_BAD;
                    end
                  end
                  default: begin
                    if (hex_st_nxt == HX_ZERO || hex_st_nxt == HX_DIGITS) hex_st_nxt = HX_STOP;
                  end
                endcase
              end

              if (byte_r == CH_CR) begin
                cr_nxt = 1'b1;
              end else begin
                // ordinary line character
                unique case (phase_nxt)
                  PH_STATUS: begin
                    line_st_nxt = 1'b1;
                    if (byte_r == CH_SP) begin
                      in_token_nxt = 1'b0;
                    end else begin
                      if (!in_token_nxt) begin
                        in_token_nxt = 1'b1;
                        if (tok_nxt < TOK_MAX) tok_nxt = tok_nxt + 2'd1;
                      end
                      if (tok_nxt == TOK_CODE) begin
                        if (vms_nxt == SV_START) begin
                          if (!b_ws) begin
                            if (byte_r == CH_PLUS) begin
                              vms_nxt = SV_PLUS;
                            end else if (b_dec) begin
                              vms_nxt      = SV_DIGITS;
                              stat_acc_nxt = {6'd0, b_digit};
                            end else begin
                              vms_nxt = SV_BAD;
                            end
                          end
                        end else if (vms_nxt == SV_PLUS) begin
                          if (b_dec) begin
                            vms_nxt      = SV_DIGITS;
                            stat_acc_nxt = {6'd0, b_digit};
                          end else begin
                            vms_nxt = SV_BAD;
                          end
                        end else if (vms_nxt == SV_DIGITS) begin
                          if (b_dec) stat_acc_nxt = stat_push;
                          else vms_nxt = SV_END;
                        end
                      end
                    end
                  end
                  PH_HNAME: begin
                    line_st_nxt = 1'b1;
                    if (byte_r == CH_COLON) begin
                      if (cand_nxt[0] && pos_nxt == CL_LEN) cand_nxt = CAND_CL;
                      else if (cand_nxt[1] && pos_nxt == TE_LEN) cand_nxt = CAND_TE;
                      else cand_nxt = CAND_NONE;
                      vms_nxt   = 4'd0;
                      num_nxt   = LEN_ZERO;
                      phase_nxt = PH_HVALUE;
                    end else begin
                      if (!(pos_nxt < CL_LEN && cl_char(pos_nxt) == byte_r)) cand_nxt[0] = 1'b0;
                      if (!(pos_nxt < TE_LEN && te_char(pos_nxt) == byte_r)) cand_nxt[1] = 1'b0;
                      if (pos_nxt < POS_MAX) pos_nxt = pos_nxt + 5'd1;
                    end
                  end
                  PH_HVALUE: begin
                    if (cand_nxt == CAND_CL) begin
                      // decimal Content-Length
                      if (vms_nxt == LV_START) begin
                        if (!b_ws) begin
                          if (byte_r == CH_PLUS) begin
                            vms_nxt = LV_PLUS;
                          end else if (byte_r == CH_MINUS) begin
                            vms_nxt = LV_MINUS;
                          end else if (b_dec) begin
                            vms_nxt = LV_DIGITS;
                            num_nxt = {{(LENGTH_BITS-4){1'b0}}, b_digit};
                          end else begin
                            vms_nxt = LV_BAD;
                          end
                        end
                      end else if (vms_nxt == LV_PLUS) begin
                        if (b_dec) begin
                          vms_nxt = LV_DIGITS;
                          num_nxt = {{(LENGTH_BITS-4){1'b0}}, b_digit};
                        end else begin
                          vms_nxt = LV_BAD;
                        end
                      end else if (vms_nxt == LV_MINUS) begin
                        vms_nxt = b_dec ? LV_NEGDIG : LV_BAD;
                      end else if (vms_nxt == LV_DIGITS) begin
                        if (b_dec) num_nxt = dec_push;
                        else vms_nxt = LV_END;
                      end else if (vms_nxt == LV_NEGDIG) begin
                        if (!b_dec) vms_nxt = LV_NEGEND;
                      end
                    end else if (cand_nxt == CAND_TE) begin
                      // "chunked", surrounding white space allowed
                      if (vms_nxt == EV_START) begin
                        if (!b_ws) vms_nxt = (byte_r == CH_LC_C) ? EV_FIRST : EV_BAD;
                      end else if (vms_nxt >= EV_FIRST && vms_nxt <= EV_LAST) begin
                        vms_nxt = (ck_char(vms_nxt) == byte_r) ? vms_nxt + 4'd1 : EV_BAD;
                      end else if (vms_nxt == EV_MATCHED) begin
                        if (!b_ws) vms_nxt = EV_BAD;
                      end
                    end
                  end
                  default: begin
                    // hex chunk size
                    unique case (hex_st_nxt)
                      HX_START: begin
                        if (!b_ws) begin
                          if (!b_hex[4]) begin
                            hex_st_nxt = HX_STOP;
                          end else begin
                            hex_seen_nxt = 1'b1;
                            num_nxt      = {{(LENGTH_BITS-4){1'b0}}, b_hex[3:0]};
                            hex_st_nxt   = (b_hex[3:0] == 4'd0) ? HX_ZERO : HX_DIGITS;
                          end
                        end
                      end
                      HX_ZERO, HX_DIGITS: begin
                        if (hex_st_nxt == HX_ZERO && (byte_r == CH_LC_X || byte_r == CH_UC_X)) begin
                          hex_st_nxt = HX_DIGITS;
                        end else if (!b_hex[4]) begin
                          hex_st_nxt = HX_STOP;
                        end else begin
                          num_nxt    = hex_push;
                          hex_st_nxt = HX_DIGITS;
                        end
                      end
                      default: ;
                    endcase
                  end
                endcase
              end
            end
          end
          PH_BODY: begin
            r_bvalid = 1'b1;
            r_byte   = byte_r;
            if (body_cnt_nxt != LEN_MASK) body_cnt_nxt = body_cnt_nxt + LEN_ONE;
          end
          PH_CDATA: begin
            r_bvalid = 1'b1;
            r_byte   = byte_r;
            if (chunk_rem_nxt != LEN_ZERO) chunk_rem_nxt = chunk_rem_nxt - LEN_ONE;
            if (chunk_rem_nxt == LEN_ZERO) begin
              phase_nxt = PH_CTRAIL;
              trail_nxt = TRAIL_SKIP;
            end
          end
          PH_CTRAIL: begin
            if (trail_nxt != 2'd0) trail_nxt = trail_nxt - 2'd1;
            if (trail_nxt == 2'd0) begin
              phase_nxt    = PH_CSIZE;
              hex_st_nxt   = HX_START;
              hex_seen_nxt = 1'b0;
              num_nxt      = LEN_ZERO;
              cr_nxt       = 1'b0;
            end
          end
          default: ;
        endcase

        // plain body ends at a segment boundary once the length is met, or at any boundary if no length is known
        if (!fin_nxt && phase_nxt == PH_BODY && seg_r &&
            (!len_known_nxt || body_cnt_nxt >= len_nxt)) begin
          fin_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      res_valid = r_bvalid || fin_nxt;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      phase_r     <= PH_STATUS;
      cr_r        <= 1'b0;
      tok_r       <= 2'd0;
      stat_val_r  <= 10'd0;
      stat_acc_r  <= 10'd0;
      in_token_r  <= 1'b0;
      pos_r       <= 5'd0;
      cand_r      <= CAND_BOTH;
      vms_r       <= 4'd0;
      num_r       <= LEN_ZERO;
      len_r       <= LEN_ZERO;
      len_known_r <= 1'b0;
      chunked_r   <= 1'b0;
      chunk_rem_r <= LEN_ZERO;
      hex_st_r    <= HX_START;
      hex_seen_r  <= 1'b0;
      trail_r     <= 2'd0;
      body_cnt_r  <= LEN_ZERO;
      fin_r       <= 1'b0;
      line_st_r   <= 1'b0;
    end else begin
      // input register
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
        cmd_r  <= in_tuser[1:0];
        newr_r <= in_tuser[2];
        hdr_r  <= in_tuser[3];
        byte_r <= in_tdata;
        seg_r  <= in_tlast;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end

      // state and output register
      if (advance) begin
        phase_r     <= phase_nxt;
        cr_r        <= cr_nxt;
        tok_r       <= tok_nxt;
        stat_val_r  <= stat_val_nxt;
        stat_acc_r  <= stat_acc_nxt;
        in_token_r  <= in_token_nxt;
        pos_r       <= pos_nxt;
        cand_r      <= cand_nxt;
        vms_r       <= vms_nxt;
        num_r       <= num_nxt;
        len_r       <= len_nxt;
        len_known_r <= len_known_nxt;
        chunked_r   <= chunked_nxt;
        chunk_rem_r <= chunk_rem_nxt;
        hex_st_r    <= hex_st_nxt;
        hex_seen_r  <= hex_seen_nxt;
        trail_r     <= trail_nxt;
        body_cnt_r  <= body_cnt_nxt;
        fin_r       <= fin_nxt;
        line_st_r   <= line_st_nxt;
        out_v_r     <= res_valid;
        if (res_valid) begin
          o_bvalid_r  <= r_bvalid;
          o_byte_r    <= r_byte;
          o_done_r    <= fin_nxt;
          o_outcome_r <= r_outcome;
          o_status_r  <= stat_val_nxt;
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, o_status_r, o_byte_r};
  assign out_tuser  = {o_outcome_r, o_bvalid_r};
  assign out_tlast  = o_done_r;

endmodule
